// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: rtl/core/psfpd_pkg.sv
// Shared types and constants of the pendulum PD controller.
`default_nettype none
package psfpd_pkg;
	localparam int unsigned CordicSteps = 23;
	localparam int unsigned StepW = 5;

	typedef enum logic [2:0] {
		CFG_GAIN_WHEEL_ANGLE = 3'd0,
		CFG_GAIN_WHEEL_RATE  = 3'd1,
		CFG_GAIN_TILT        = 3'd2,
		CFG_GAIN_TILT_RATE   = 3'd3,
		CFG_INV_TIME_STEP    = 3'd4
	} cfg_idx_t;

	// One classified request as it travels from the front to the back.
	typedef struct packed {
		logic signed [31:0] wheel_angle;
		logic signed [15:0] accel_x;
		logic [31:0]        perp_sq;   // ay^2 + az^2
		logic               zero_vec;
	} req_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQRT, ST_CORDIC, ST_DIFF, ST_RATE_Q, ST_RATE_T,
		ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_DONE
	} back_state_t;

	function automatic logic signed [22:0] atan_deg(input logic [StepW-1:0] i);
		logic signed [22:0] r;
		begin
			case (i)
				5'd0: r = 23'sd2949120;  5'd1: r = 23'sd1740967;
				5'd2: r = 23'sd919879;   5'd3: r = 23'sd466945;
				5'd4: r = 23'sd234379;   5'd5: r = 23'sd117304;
				5'd6: r = 23'sd58666;    5'd7: r = 23'sd29335;
				5'd8: r = 23'sd14668;    5'd9: r = 23'sd7334;
				5'd10: r = 23'sd3667;    5'd11: r = 23'sd1833;
				5'd12: r = 23'sd917;     5'd13: r = 23'sd458;
				5'd14: r = 23'sd229;     5'd15: r = 23'sd115;
				5'd16: r = 23'sd57;      5'd17: r = 23'sd29;
				5'd18: r = 23'sd14;      5'd19: r = 23'sd7;
				5'd20: r = 23'sd4;       5'd21: r = 23'sd2;
				5'd22: r = 23'sd1;
				default: r = 23'sd0;
			endcase
			return r;
		end
	endfunction
endpackage
`default_nettype wire

// File: rtl/core/psfpd_front.sv
// Front stage: registers a request and squares the perpendicular components.
`default_nettype none
module psfpd_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] wheel_angle,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_z,
	output logic                    q_push,
	output psfpd_pkg::req_t         q_data,
	input  wire logic               q_full
);
	logic                    busy_q;
	logic                    sq_done_q;
	logic signed [31:0]      wa_q;
	logic signed [15:0]      ax_q, ay_q, az_q;
	logic [31:0]             ysq_q, zsq_q;

	assign in_stall = busy_q;

	// The two squares are registered in parallel; their sum is formed combinationally.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sq_done_q <= 1'b0;
		end else if (!busy_q) begin
			if (in_valid) begin
				busy_q <= 1'b1;
				sq_done_q <= 1'b0;
			end
		end else if (!sq_done_q) begin
			sq_done_q <= 1'b1;
		end else if (!q_full) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && in_valid) begin
			wa_q <= wheel_angle;
			ax_q <= accel_x;
			ay_q <= accel_y;
			az_q <= accel_z;
		end
		if (busy_q && !sq_done_q) begin
			ysq_q <= 32'(ay_q * ay_q);
			zsq_q <= 32'(az_q * az_q);
		end
	end

	assign q_push = busy_q && sq_done_q && !q_full;
	always_comb begin
		q_data.wheel_angle = wa_q;
		q_data.accel_x = ax_q;
		q_data.perp_sq = ysq_q + zsq_q;
		q_data.zero_vec = (ax_q == '0) && (ay_q == '0) && (az_q == '0);
	end
endmodule
`default_nettype wire

// File: rtl/core/psfpd_queue.sv
// Two-entry request queue between the front and the back.
`default_nettype none
module psfpd_queue (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  psfpd_pkg::req_t wdata,
	output logic            full,
	input  wire logic       pop,
	output psfpd_pkg::req_t rdata,
	output logic            not_empty
);
	psfpd_pkg::req_t mem_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;

	assign full = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end
endmodule
`default_nettype wire

// File: rtl/core/psfpd_back.sv
// Back stage: square root, CORDIC tilt, rates, gain products and saturation.
`default_nettype none
module psfpd_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  psfpd_pkg::req_t         q_data,
	output logic                    q_pop,
	input  wire logic signed [31:0] gain_wheel_angle,
	input  wire logic signed [31:0] gain_wheel_rate,
	input  wire logic signed [31:0] gain_tilt,
	input  wire logic signed [31:0] gain_tilt_rate,
	input  wire logic [31:0]        inv_time_step,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      torque,
	output logic                    saturated
);
	psfpd_pkg::back_state_t state_q, state_d;
	psfpd_pkg::req_t        req_q;
	logic [4:0]             cnt_q;
	// Square root of perp_sq * 2^16 (48-bit radicand, 24-bit root).
	logic [47:0]            rad_q;
	logic [25:0]            rem_q;
	logic [23:0]            root_q;
	// CORDIC vectors; x grows to about 1.65 * 2^24.
	logic signed [27:0]     cx_q, cy_q;
	logic signed [31:0]     cz_q;
	logic signed [31:0]     last_wa_q, last_tilt_q;
	logic                   primed_q;
	logic signed [33:0]     dq_q, dt_q;
	logic signed [31:0]     rate_wa_q, rate_tilt_q;
	logic signed [65:0]     prod_q;
	logic signed [65:0]     acc_q;
	logic                   out_valid_q;
	logic signed [31:0]     torque_q;
	logic                   sat_q;

	logic [25:0]            trial;
	logic signed [27:0]     sy, sx;
	logic signed [33:0]     dsel;
	logic [32:0]            mag;
	logic [64:0]            pmag;
	logic [32:0]            pclip;
	logic signed [31:0]     rsat;
	logic signed [31:0]     mgain;
	logic signed [32:0]     mval;

	// Rate unit: sign-magnitude product, shifted, clipped to 2^32, then to 32 bits.
	always_comb begin
		dsel = (state_q == psfpd_pkg::ST_RATE_Q) ? dq_q : dt_q;
		mag = dsel[33] ? 33'(-dsel) : 33'(dsel);
		pmag = 65'(mag * inv_time_step);
		pclip = (pmag[64:16] > 49'h100000000) ? 33'h100000000 : 33'(pmag[64:16]);
		if (dsel[33]) rsat = (pclip >= 33'h80000000) ? 32'sh80000000 : 32'(-pclip);
		else rsat = (pclip >= 33'h80000000) ? 32'sh7fffffff : 32'(pclip);
	end

	// Restoring digit recurrence for the square root.
	always_comb begin
		trial = {rem_q[23:0], rad_q[47:46]} - {root_q, 2'b01};
	end

	always_comb begin
		sy = cy_q >>> cnt_q;
		sx = cx_q >>> cnt_q;
	end

	always_comb begin
		unique case (state_q)
			psfpd_pkg::ST_MUL0: begin mgain = gain_wheel_angle; mval = -33'(req_q.wheel_angle); end
			psfpd_pkg::ST_MUL1: begin mgain = gain_wheel_rate; mval = -33'(rate_wa_q); end
			psfpd_pkg::ST_MUL2: begin mgain = gain_tilt; mval = -33'(cz_q); end
			psfpd_pkg::ST_MUL3: begin mgain = gain_tilt_rate; mval = -33'(rate_tilt_q); end
			default: begin mgain = '0; mval = '0; end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			psfpd_pkg::ST_IDLE: if (q_valid) state_d = psfpd_pkg::ST_SQRT;
			psfpd_pkg::ST_SQRT: if (cnt_q == 5'd23) state_d = psfpd_pkg::ST_CORDIC;
			psfpd_pkg::ST_CORDIC: if (cnt_q == 5'(psfpd_pkg::CordicSteps - 1))
				state_d = psfpd_pkg::ST_DIFF;
			psfpd_pkg::ST_DIFF: state_d = psfpd_pkg::ST_RATE_Q;
			psfpd_pkg::ST_RATE_Q: state_d = psfpd_pkg::ST_RATE_T;
			psfpd_pkg::ST_RATE_T: state_d = psfpd_pkg::ST_MUL0;
			psfpd_pkg::ST_MUL0: state_d = psfpd_pkg::ST_MUL1;
			psfpd_pkg::ST_MUL1: state_d = psfpd_pkg::ST_MUL2;
			psfpd_pkg::ST_MUL2: state_d = psfpd_pkg::ST_MUL3;
			psfpd_pkg::ST_MUL3: state_d = psfpd_pkg::ST_DONE;
			psfpd_pkg::ST_DONE: if (!out_valid_q || !out_stall) state_d = psfpd_pkg::ST_IDLE;
			default: state_d = psfpd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == psfpd_pkg::ST_IDLE) && q_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psfpd_pkg::ST_IDLE;
			primed_q <= 1'b0;
			last_wa_q <= '0;
			last_tilt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (state_q == psfpd_pkg::ST_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
				primed_q <= 1'b1;
				last_wa_q <= req_q.wheel_angle;
				last_tilt_q <= cz_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			psfpd_pkg::ST_IDLE: begin
				req_q <= q_data;
				rad_q <= {q_data.perp_sq, 16'h0};
				rem_q <= '0;
				root_q <= '0;
				cnt_q <= '0;
			end
			psfpd_pkg::ST_SQRT: begin
				if (cnt_q == 5'd23) begin
					// The last root bit is decided in this same cycle.
					cx_q <= 28'({4'h0, root_q[22:0], ~trial[25]});
					cy_q <= 28'(req_q.accel_x) <<< 8;
					cz_q <= '0;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + 5'd1;
				end
				rad_q <= rad_q << 2;
				if (!trial[25]) begin
					rem_q <= trial;
					root_q <= {root_q[22:0], 1'b1};
				end else begin
					rem_q <= {rem_q[23:0], rad_q[47:46]};
					root_q <= {root_q[22:0], 1'b0};
				end
			end
			psfpd_pkg::ST_CORDIC: begin
				cnt_q <= cnt_q + 5'd1;
				if (!cy_q[27]) begin
					cx_q <= cx_q + sy;
					cy_q <= cy_q - sx;
					cz_q <= cz_q + 32'(psfpd_pkg::atan_deg(cnt_q));
				end else begin
					cx_q <= cx_q - sy;
					cy_q <= cy_q + sx;
					cz_q <= cz_q - 32'(psfpd_pkg::atan_deg(cnt_q));
				end
			end
			psfpd_pkg::ST_DIFF: begin
				if (req_q.zero_vec) cz_q <= '0;
				if (primed_q) begin
					dq_q <= 34'(req_q.wheel_angle) - 34'(last_wa_q);
					dt_q <= 34'(req_q.zero_vec ? 32'sd0 : cz_q) - 34'(last_tilt_q);
				end else begin
					dq_q <= '0;
					dt_q <= '0;
				end
				acc_q <= '0;
			end
			psfpd_pkg::ST_RATE_Q: rate_wa_q <= rsat;
			psfpd_pkg::ST_RATE_T: rate_tilt_q <= rsat;
			psfpd_pkg::ST_MUL0, psfpd_pkg::ST_MUL1, psfpd_pkg::ST_MUL2,
			psfpd_pkg::ST_MUL3: begin
				if (state_q != psfpd_pkg::ST_MUL0) acc_q <= acc_q + (prod_q >>> 16);
				prod_q <= 66'(mgain * mval);
			end
			psfpd_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					if (acc_q + (prod_q >>> 16) > 66'sh7fffffff) begin
						torque_q <= 32'sh7fffffff; sat_q <= 1'b1;
					end else if (acc_q + (prod_q >>> 16) < -66'sh80000000) begin
						torque_q <= 32'sh80000000; sat_q <= 1'b1;
					end else begin
						torque_q <= 32'(acc_q + (prod_q >>> 16)); sat_q <= 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign torque = torque_q;
	assign saturated = sat_q;
endmodule
`default_nettype wire

// File: rtl/core/pendulum_state_feedback_pd_core.sv
// Top level of the wheeled inverted pendulum PD torque controller.
// A request passes the front, the queue and the back stage before its result is valid.
// The back stage works on one request at a time, paced by the 24-step square root
// and the 23-step CORDIC loop sharing one datapath in the back stage.
// Reset (arst_n low, asynchronous) clears control state, the history and
// the gains; inv_time_step returns to 1000.0 in Q16.16.
`default_nettype none
module pendulum_state_feedback_pd_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] wheel_angle,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_z,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      torque,
	output logic                    saturated
);
	logic signed [31:0] g_wa_q, g_wr_q, g_t_q, g_tr_q;
	logic [31:0]        its_q;
	logic               push, full, pop, not_empty;
	psfpd_pkg::req_t    wdata, rdata;

	// Configuration registers; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_wa_q <= '0;
			g_wr_q <= '0;
			g_t_q <= '0;
			g_tr_q <= '0;
			its_q <= 32'd65536000;
		end else if (cfg_we) begin
			case (cfg_index)
				psfpd_pkg::CFG_GAIN_WHEEL_ANGLE: g_wa_q <= cfg_data;
				psfpd_pkg::CFG_GAIN_WHEEL_RATE: g_wr_q <= cfg_data;
				psfpd_pkg::CFG_GAIN_TILT: g_t_q <= cfg_data;
				psfpd_pkg::CFG_GAIN_TILT_RATE: g_tr_q <= cfg_data;
				psfpd_pkg::CFG_INV_TIME_STEP: its_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The front registers a request and forms ay^2 + az^2 for the queue.
	psfpd_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .wheel_angle, .accel_x, .accel_y,
		.accel_z, .q_push(push), .q_data(wdata), .q_full(full)
	);

	psfpd_queue u_queue (
		.clk, .arst_n, .push, .wdata, .full, .pop, .rdata, .not_empty
	);

	// The back does the long iterative work and holds the result register.
	psfpd_back u_back (
		.clk, .arst_n, .q_valid(not_empty), .q_data(rdata), .q_pop(pop),
		.gain_wheel_angle(g_wa_q), .gain_wheel_rate(g_wr_q), .gain_tilt(g_t_q),
		.gain_tilt_rate(g_tr_q), .inv_time_step(its_q), .out_valid, .out_stall,
		.torque, .saturated
	);
endmodule
`default_nettype wire

// File: rtl/core/psfpd_checker.sv
// Port-level checker for the controller, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module psfpd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] torque,
	input wire logic        saturated
);
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(torque))
	`ASSERT_IMPL(a_sat_max, clk, arst_n, out_valid && saturated,
		torque == 32'h7fffffff || torque == 32'h80000000)
	`ASSERT_NEXT(a_flag_hold, clk, arst_n, out_valid && out_stall, $stable(saturated))
endmodule
bind pendulum_state_feedback_pd_core psfpd_checker u_checker (
	.clk, .arst_n, .out_valid, .out_stall, .torque, .saturated
);
`default_nettype wire

// File: test/pendulum_state_feedback_pd_core_tb.sv
// Testbench for the pendulum PD torque controller: random and directed ticks checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module pendulum_state_feedback_pd_core_tb;

	// Expected torque command of one control tick.
	typedef struct {
		logic signed [31:0] torque;
		logic               saturated;
	} torque_cmd_t;

	// Bit-exact model of the controller plus the queue of commands still due.
	class torque_scoreboard;
		longint gain_angle, gain_rate, gain_tilt, gain_tilt_rate;
		longint unsigned inv_dt;
		longint prev_angle, prev_tilt;
		bit primed;
		torque_cmd_t due[$];
		int errors;

		function void reset_state();
			gain_angle = 0;
			gain_rate = 0;
			gain_tilt = 0;
			gain_tilt_rate = 0;
			inv_dt = 64'd65536000;
			prev_angle = 0;
			prev_tilt = 0;
			primed = 0;
			due.delete();
			errors = 0;
		endfunction

		function void write_reg(psfpd_pkg::cfg_idx_t idx, logic [31:0] value);
			case (idx)
				psfpd_pkg::CFG_GAIN_WHEEL_ANGLE: gain_angle = longint'(signed'(value));
				psfpd_pkg::CFG_GAIN_WHEEL_RATE: gain_rate = longint'(signed'(value));
				psfpd_pkg::CFG_GAIN_TILT: gain_tilt = longint'(signed'(value));
				psfpd_pkg::CFG_GAIN_TILT_RATE: gain_tilt_rate = longint'(signed'(value));
				psfpd_pkg::CFG_INV_TIME_STEP: inv_dt = {32'd0, value};
				default: ;
			endcase
		endfunction

		// Arithmetic shift right is a floor division by a power of two.
		function longint floor_shift(longint v, int s);
			return v >>> s;
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > v) bitv >>= 2;
			while (bitv != 0) begin
				if (v >= res + bitv) begin
					v -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		function int atan_table(int i);
			int t [23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
				29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
			return t[i];
		endfunction

		function longint tilt_of(longint ax, longint ay, longint az);
			longint x, y, z, nx, ny, step;
			if (ax == 0 && ay == 0 && az == 0) return 0;
			x = longint'(int_sqrt(longint'(ay * ay + az * az) << 16));
			y = ax * 256;
			z = 0;
			for (int i = 0; i < psfpd_pkg::CordicSteps; i++) begin
				step = longint'(atan_table(i));
				if (y >= 0) begin
					nx = x + floor_shift(y, i);
					ny = y - floor_shift(x, i);
					z += step;
				end else begin
					nx = x - floor_shift(y, i);
					ny = y + floor_shift(x, i);
					z -= step;
				end
				x = nx;
				y = ny;
			end
			return z;
		endfunction

		// Scaled backward difference; the magnitude is kept in 128 bits.
		function longint rate_of(longint d);
			logic [127:0] p;
			longint unsigned mag;
			longint r;
			mag = (d < 0) ? longint'(-d) : d;
			p = ({64'd0, mag} * {64'd0, inv_dt}) >> 16;
			if (p > (128'd1 << 32)) p = 128'd1 << 32;
			r = longint'(p[63:0]);
			if (d < 0) r = -r;
			if (r > 64'sd2147483647) r = 64'sd2147483647;
			if (r < -64'sd2147483648) r = -64'sd2147483648;
			return r;
		endfunction

		function void note_tick(logic signed [31:0] angle, logic signed [15:0] ax,
				logic signed [15:0] ay, logic signed [15:0] az);
			longint q, tilt, dq, dt, sum;
			torque_cmd_t cmd;
			q = angle;
			tilt = tilt_of(ax, ay, az);
			if (!primed) begin
				prev_angle = q;
				prev_tilt = tilt;
				primed = 1;
			end
			dq = rate_of(q - prev_angle);
			dt = rate_of(tilt - prev_tilt);
			sum = floor_shift(gain_angle * (0 - q), 16) + floor_shift(gain_rate * (0 - dq), 16)
				+ floor_shift(gain_tilt * (0 - tilt), 16)
				+ floor_shift(gain_tilt_rate * (0 - dt), 16);
			cmd.saturated = 0;
			if (sum > 64'sd2147483647) begin
				sum = 64'sd2147483647;
				cmd.saturated = 1;
			end else if (sum < -64'sd2147483648) begin
				sum = -64'sd2147483648;
				cmd.saturated = 1;
			end
			cmd.torque = sum[31:0];
			prev_angle = q;
			prev_tilt = tilt;
			due.push_back(cmd);
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check_cmd(logic signed [31:0] torque, logic saturated);
			torque_cmd_t exp_cmd;
			if (due.size() == 0) begin
				report($sformatf("unexpected torque %0d", torque));
				return;
			end
			exp_cmd = due.pop_front();
			if (torque !== exp_cmd.torque)
				report($sformatf("torque %0d, expected %0d", torque, exp_cmd.torque));
			if (saturated !== exp_cmd.saturated)
				report($sformatf("saturated %0b, expected %0b", saturated, exp_cmd.saturated));
		endtask
	endclass

	logic clk, arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid, in_stall;
	logic signed [31:0] wheel_angle;
	logic signed [15:0] accel_x, accel_y, accel_z;
	logic out_valid, out_stall;
	logic signed [31:0] torque;
	logic saturated;

	pendulum_state_feedback_pd_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.wheel_angle(wheel_angle), .accel_x(accel_x), .accel_y(accel_y),
		.accel_z(accel_z), .out_valid(out_valid), .out_stall(out_stall),
		.torque(torque), .saturated(saturated)
	);

	torque_scoreboard board;
	int send_idle_pct, recv_stall_pct;
	bit hold_off;
	int idle_cycles;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = psfpd_pkg::CFG_GAIN_WHEEL_ANGLE;
		cfg_data = 0;
		in_valid = 0;
		wheel_angle = 0;
		accel_x = 0;
		accel_y = 0;
		accel_z = 0;
		out_stall = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 0;
		board = new();
		board.reset_state();
		repeat (5) @(posedge clk);
		arst_n <= 1;
	end

	// Receiver side: outputs are sampled at the edge, stall is redrawn after it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) board.check_cmd(torque, saturated);
			out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog: a long run with no request or result accepted ends the test.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 20000) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic write_cfg(psfpd_pkg::cfg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		board.write_reg(idx, value);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// Offers one tick and returns once the block has taken it.
	task automatic send_tick(logic signed [31:0] q, logic signed [15:0] ax,
			logic signed [15:0] ay, logic signed [15:0] az);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		wheel_angle <= q;
		accel_x <= ax;
		accel_y <= ay;
		accel_z <= az;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_tick(q, ax, ay, az);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.due.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// Angle mostly moves in small steps so rates stay in range, with some wild jumps.
	task automatic random_tick(inout logic signed [31:0] q);
		logic signed [15:0] ax, ay, az;
		case ($urandom_range(9))
			0: q = $urandom;
			1, 2: q = q + $signed($urandom_range(4000)) - 2000;
			default: q = q + $signed($urandom_range(400000)) - 200000;
		endcase
		ax = $urandom;
		ay = $urandom;
		az = $urandom;
		if ($urandom_range(19) == 0) begin
			ax = 0;
			ay = 0;
			az = 0;
		end else if ($urandom_range(9) == 0) begin
			ax = $signed($urandom_range(32)) - 16;
		end
		send_tick(q, ax, ay, az);
	endtask

	function automatic logic [31:0] random_gain();
		case ($urandom_range(5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom;
			default: return $signed($urandom_range(20'hfffff)) - 20'sh7ffff;
		endcase
	endfunction

	initial begin
		logic signed [31:0] q;
		wait (arst_n);
		@(posedge clk);
		write_cfg(psfpd_pkg::CFG_GAIN_WHEEL_ANGLE, 32'h0001_0000);
		write_cfg(psfpd_pkg::CFG_GAIN_WHEEL_RATE, 32'h0000_4000);
		write_cfg(psfpd_pkg::CFG_GAIN_TILT, 32'hffff_0000);
		write_cfg(psfpd_pkg::CFG_GAIN_TILT_RATE, 32'h0000_0100);

		// Directed: first tick primes, zero vector, axis extremes, angle extremes.
		send_tick(32'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_tick(32'sh7fff_ffff, 16'sh7fff, 16'sd0, 16'sd0);
		send_tick(32'sh8000_0000, -16'sh8000, 16'sd0, 16'sd0);
		send_tick(32'sd65536, 16'sd0, 16'sh7fff, 16'sd0);
		send_tick(-32'sd65536, 16'sd100, 16'sd0, -16'sh8000);
		send_tick(32'sd1, -16'sh8000, -16'sh8000, -16'sh8000);
		send_tick(32'sd0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_tick(32'sd0, 16'sd1, 16'sd0, 16'sd0);
		send_tick(32'sd0, -16'sd1, 16'sd1, 16'sd0);
		send_tick(32'sd0, 16'sd0, 16'sd0, 16'sd0);
		drain();
		// Extreme gains force saturation in both directions.
		write_cfg(psfpd_pkg::CFG_GAIN_WHEEL_ANGLE, 32'h7fff_ffff);
		write_cfg(psfpd_pkg::CFG_GAIN_WHEEL_RATE, 32'h8000_0000);
		write_cfg(psfpd_pkg::CFG_GAIN_TILT, 32'h7fff_ffff);
		write_cfg(psfpd_pkg::CFG_GAIN_TILT_RATE, 32'h8000_0000);
		write_cfg(psfpd_pkg::CFG_INV_TIME_STEP, 32'hffff_ffff);
		send_tick(32'sh7fff_ffff, 16'sh7fff, 16'sd0, 16'sd0);
		send_tick(32'sh8000_0000, -16'sh8000, 16'sd0, 16'sd0);
		send_tick(32'sh7fff_ffff, 16'sd0, 16'sd5, 16'sd5);
		send_tick(-32'sd5, 16'sd3, 16'sd0, 16'sd0);
		drain();
		write_cfg(psfpd_pkg::CFG_INV_TIME_STEP, 32'd0);
		send_tick(32'sh4000_0000, 16'sd1000, 16'sd2000, 16'sd3000);
		send_tick(-32'sh4000_0000, -16'sd1000, 16'sd2000, 16'sd3000);
		drain();

		// Random phases: each sets new registers and an idling pattern.
		q = 0;
		for (int ph = 0; ph < 8; ph++) begin
			write_cfg(psfpd_pkg::CFG_GAIN_WHEEL_ANGLE, random_gain());
			write_cfg(psfpd_pkg::CFG_GAIN_WHEEL_RATE, random_gain());
			write_cfg(psfpd_pkg::CFG_GAIN_TILT, random_gain());
			write_cfg(psfpd_pkg::CFG_GAIN_TILT_RATE, random_gain());
			case (ph % 3)
				0: write_cfg(psfpd_pkg::CFG_INV_TIME_STEP, 32'd65536000);
				1: write_cfg(psfpd_pkg::CFG_INV_TIME_STEP, $urandom);
				default: write_cfg(psfpd_pkg::CFG_INV_TIME_STEP, $urandom_range(32'd70000000));
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 73; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 73; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			if (ph == 2) begin
				// Long receiver hold-off while the sender keeps offering.
				fork
					begin
						hold_off = 1;
						repeat (600) @(posedge clk);
						hold_off = 0;
					end
				join_none
			end
			for (int n = 0; n < 200; n++) begin
				random_tick(q);
				// The sender waits out every pending command now and then.
				if ($urandom_range(99) == 0) drain();
			end
			drain();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		if (board.errors == 0 && board.due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
`default_nettype wire
